// File: design/fus_pkg.sv
package fus_pkg;

    // field widths
    localparam int STATE_W = 4;
    localparam int TIME_W  = 27;
    localparam int CNT_W   = 8;
    localparam int SIZE_W  = 32;
    localparam int LEN_W   = 13;
    localparam int CFG_W   = 27;
    localparam int IDX_W   = 3;

    // parameter defaults
    localparam int CHUNK_BYTES_DEF  = 4096;
    localparam int MODE_POLL_MS_DEF = 2500;
    localparam int IDLE_POLL_MS_DEF = 24 * 60 * 60 * 1000;

    // register indexes
    localparam logic [IDX_W-1:0] REG_REQ_ATTEMPTS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_REQ_INTERVAL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CHK_INTERVAL  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MODE_TIMEOUT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_UPD_PRESENT   = 3'd4;

    // register reset values
    localparam logic [CNT_W-1:0]  RST_REQ_ATTEMPTS = 8'd5;
    localparam logic [TIME_W-1:0] RST_REQ_INTERVAL = 27'd5000;
    localparam logic [TIME_W-1:0] RST_CHK_INTERVAL = 27'd60000;
    localparam logic [TIME_W-1:0] RST_MODE_TIMEOUT = 27'd120000;

    // sequencer state codes
    localparam logic [STATE_W-1:0] S_UNAVAIL  = 4'd0;
    localparam logic [STATE_W-1:0] S_INITIAL  = 4'd1;
    localparam logic [STATE_W-1:0] S_REPORT   = 4'd2;
    localparam logic [STATE_W-1:0] S_CHECK    = 4'd3;
    localparam logic [STATE_W-1:0] S_AVAIL    = 4'd4;
    localparam logic [STATE_W-1:0] S_REQMODE  = 4'd5;
    localparam logic [STATE_W-1:0] S_CHKMODE  = 4'd6;
    localparam logic [STATE_W-1:0] S_BEGIN    = 4'd7;
    localparam logic [STATE_W-1:0] S_RETRIEVE = 4'd8;
    localparam logic [STATE_W-1:0] S_STORE    = 4'd9;
    localparam logic [STATE_W-1:0] S_FINAL    = 4'd10;
    localparam logic [STATE_W-1:0] S_LEAVE    = 4'd11;
    localparam logic [STATE_W-1:0] S_DELETE   = 4'd12;
    localparam logic [STATE_W-1:0] S_EXEC     = 4'd13;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef struct packed {
        logic              operation;
        logic              force_req;
        logic              action_ok;
        logic              image_ready;
        logic              image_same_version;
        logic [SIZE_W-1:0] image_length;
    } in_word_t;

    typedef struct packed {
        logic [STATE_W-1:0] current_state;
        logic               state_ran;
        logic [TIME_W-1:0]  wait_ms;
        logic [SIZE_W-1:0]  fetch_offset;
        logic [LEN_W-1:0]   fetch_length;
        logic               discard_flag;
        logic               transferred_flag;
        logic               execute_pulse;
        logic [CNT_W-1:0]   attempts_used;
    } out_word_t;

endpackage

// File: design/firmware_update_sequencer.sv
// Firmware update sequencer.
// Input channel (in_valid / in_stall) carries one word per tick or poll:
// operation 0 is a one millisecond tick that only counts the timers down,
// operation 1 is a poll that runs the current state when it is new, forced
// or its retry wait has run out. Each input word gives exactly one output
// word on the output channel (out_valid / out_stall) with the state after
// the step, the remaining wait, the fetch window and the image flags.
// A word is held in the input register, then passes through the state
// update into the output register. Throughput is one word per cycle while
// the output is not stalled; the state update reads the state registers directly.
// Configuration (cfg_write / cfg_index / cfg_data) writes a register at the
// clock edge; write only while no word is in flight. Indexes past the last
// register are ignored.
// Reset (rst_n low, asynchronous) puts the sequencer in the initial state
// marked as new, loads the register defaults and empties both stages.
// A stall on the output holds the output word; the input register then
// fills and in_stall rises until the output word is taken.
module firmware_update_sequencer #(
    parameter int CHUNK_BYTES  = fus_pkg::CHUNK_BYTES_DEF,
    parameter int MODE_POLL_MS = fus_pkg::MODE_POLL_MS_DEF,
    parameter int IDLE_POLL_MS = fus_pkg::IDLE_POLL_MS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_write,
    input  logic [fus_pkg::IDX_W-1:0]    cfg_index,
    input  logic [fus_pkg::CFG_W-1:0]    cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic                         force_req,
    input  logic                         action_ok,
    input  logic                         image_ready,
    input  logic                         image_same_version,
    input  logic [fus_pkg::SIZE_W-1:0]   image_length,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fus_pkg::STATE_W-1:0]  current_state,
    output logic                         state_ran,
    output logic [fus_pkg::TIME_W-1:0]   wait_ms,
    output logic [fus_pkg::SIZE_W-1:0]   fetch_offset,
    output logic [fus_pkg::LEN_W-1:0]    fetch_length,
    output logic                         discard_flag,
    output logic                         transferred_flag,
    output logic                         execute_pulse,
    output logic [fus_pkg::CNT_W-1:0]    attempts_used
);
    import fus_pkg::*;

    localparam logic [SIZE_W-1:0] CHUNK_W32 = SIZE_W'(CHUNK_BYTES);
    localparam logic [TIME_W-1:0] MODE_POLL = TIME_W'(MODE_POLL_MS);
    localparam logic [TIME_W-1:0] IDLE_POLL = TIME_W'(IDLE_POLL_MS);

    // chunk length for a given remainder, min(chunk, left) cut to port width
    function automatic logic [LEN_W-1:0] chunk_of(input logic [SIZE_W-1:0] left);
        logic [SIZE_W-1:0] m;
        m = (left > CHUNK_W32) ? CHUNK_W32 : left;
        return m[LEN_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0]  req_attempts_reg;
    logic [TIME_W-1:0] req_interval_reg;
    logic [TIME_W-1:0] chk_interval_reg;
    logic [TIME_W-1:0] mode_timeout_reg;
    logic              upd_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_attempts_reg <= RST_REQ_ATTEMPTS;
            req_interval_reg <= RST_REQ_INTERVAL;
            chk_interval_reg <= RST_CHK_INTERVAL;
            mode_timeout_reg <= RST_MODE_TIMEOUT;
            upd_present_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REQ_ATTEMPTS: req_attempts_reg <= cfg_data[CNT_W-1:0];
                REG_REQ_INTERVAL: req_interval_reg <= cfg_data[TIME_W-1:0];
                REG_CHK_INTERVAL: chk_interval_reg <= cfg_data[TIME_W-1:0];
                REG_MODE_TIMEOUT: mode_timeout_reg <= cfg_data[TIME_W-1:0];
                REG_UPD_PRESENT:  upd_present_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     fire;
    logic     out_valid_reg;

    // process the held word whenever the output register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= '{operation, force_req, action_ok, image_ready,
                             image_same_version, image_length};
        end
    end

    // ---------------- sequencer state ----------------
    logic [STATE_W-1:0] state_reg,     state_next;
    logic               new_flag_reg,  new_flag_next;
    logic [CNT_W-1:0]   limit_reg,     limit_next;
    logic [CNT_W-1:0]   retry_reg,     retry_next;
    logic [TIME_W-1:0]  next_dur_reg,  next_dur_next;
    logic [TIME_W-1:0]  next_rem_reg,  next_rem_next;
    logic [TIME_W-1:0]  tmo_dur_reg,   tmo_dur_next;
    logic [TIME_W-1:0]  tmo_rem_reg,   tmo_rem_next;
    logic [SIZE_W-1:0]  size_reg,      size_next;
    logic [SIZE_W-1:0]  offset_reg,    offset_next;
    // bytes left, image size minus offset clipped at zero, kept alongside
    logic [SIZE_W-1:0]  left_reg,      left_next;
    logic [LEN_W-1:0]   chunk_reg,     chunk_next;
    logic               done_reg,      done_next;
    logic               discard_reg,   discard_next;

    logic               ran;
    logic               pulse;
    logic               go_en;
    logic [STATE_W-1:0] go_tgt;
    logic               retry_en;
    logic [STATE_W-1:0] retry_tgt;
    logic               fail;
    logic [CNT_W-1:0]   retry_inc;
    logic               avail;
    logic [SIZE_W-1:0]  offset_sum;
    in_word_t           w;

    assign w          = in_word_reg;
    assign retry_inc  = retry_reg + CNT_W'(1);
    assign offset_sum = offset_reg + SIZE_W'(chunk_reg);

    always_comb
    begin
        state_next    = state_reg;
        new_flag_next = new_flag_reg;
        limit_next    = limit_reg;
        retry_next    = retry_reg;
        next_dur_next = next_dur_reg;
        next_rem_next = next_rem_reg;
        tmo_dur_next  = tmo_dur_reg;
        tmo_rem_next  = tmo_rem_reg;
        size_next     = size_reg;
        offset_next   = offset_reg;
        left_next     = left_reg;
        chunk_next    = chunk_reg;
        done_next     = done_reg;
        discard_next  = discard_reg;
        ran           = 1'b0;
        pulse         = 1'b0;
        go_en         = 1'b0;
        go_tgt        = state_reg;
        retry_en      = 1'b0;
        retry_tgt     = state_reg;
        fail          = 1'b0;
        avail         = 1'b0;

        if (w.operation == OP_TICK)
        begin
            if (next_rem_reg != '0)
                next_rem_next = next_rem_reg - TIME_W'(1);
            if (tmo_rem_reg != '0)
                tmo_rem_next = tmo_rem_reg - TIME_W'(1);
        end
        else if (new_flag_reg || w.force_req || next_rem_reg == '0)
        begin
            new_flag_next = 1'b0;
            ran           = 1'b1;
            unique case (state_reg)
                S_UNAVAIL:
                begin
                    go_en  = 1'b1;
                    go_tgt = S_UNAVAIL;
                end
                S_INITIAL:
                begin
                    go_en  = 1'b1;
                    go_tgt = upd_present_reg ? S_REPORT : S_UNAVAIL;
                end
                S_REPORT:
                begin
                    go_en     = w.action_ok;
                    go_tgt    = S_CHECK;
                    retry_en  = !w.action_ok;
                    retry_tgt = S_REPORT;
                end
                S_CHECK:
                begin
                    if (w.action_ok && w.image_ready)
                    begin
                        size_next = w.image_length;
                        left_next = (offset_reg > w.image_length) ? '0
                                    : w.image_length - offset_reg;
                        avail     = !w.image_same_version && w.image_length != '0;
                    end
                    else
                    begin
                        size_next = '0;
                        left_next = '0;
                    end
                    go_en     = avail;
                    go_tgt    = S_AVAIL;
                    retry_en  = !avail;
                    retry_tgt = S_CHECK;
                end
                S_AVAIL:
                begin
                    go_en  = 1'b1;
                    go_tgt = S_REQMODE;
                end
                S_REQMODE:
                begin
                    go_en     = w.action_ok;
                    go_tgt    = S_CHKMODE;
                    retry_en  = !w.action_ok;
                    retry_tgt = S_CHECK;
                end
                S_CHKMODE:
                begin
                    go_en     = w.action_ok;
                    go_tgt    = S_BEGIN;
                    retry_en  = !w.action_ok;
                    retry_tgt = S_CHECK;
                end
                S_BEGIN:
                begin
                    done_next = 1'b0;
                    go_en     = 1'b1;
                    if (w.action_ok)
                    begin
                        discard_next = 1'b0;
                        offset_next  = '0;
                        left_next    = size_reg;
                        go_tgt       = S_RETRIEVE;
                    end
                    else
                    begin
                        discard_next = 1'b1;
                        go_tgt       = S_LEAVE;
                    end
                end
                S_RETRIEVE:
                begin
                    chunk_next = w.action_ok ? chunk_of(left_reg) : '0;
                    go_en      = w.action_ok;
                    go_tgt     = S_STORE;
                    retry_en   = !w.action_ok;
                    retry_tgt  = S_LEAVE;
                end
                S_STORE:
                begin
                    chunk_next = '0;
                    go_en      = 1'b1;
                    if (w.action_ok)
                    begin
                        // chunk never exceeds the bytes left, so no underflow
                        offset_next = offset_sum;
                        left_next   = left_reg - SIZE_W'(chunk_reg);
                        go_tgt      = (size_reg != '0 && offset_sum == size_reg)
                                      ? S_FINAL : S_RETRIEVE;
                    end
                    else
                    begin
                        go_tgt = S_LEAVE;
                    end
                end
                S_FINAL:
                begin
                    if (w.action_ok)
                    begin
                        done_next    = 1'b1;
                        discard_next = 1'b1;
                    end
                    go_en  = 1'b1;
                    go_tgt = S_LEAVE;
                end
                S_LEAVE:
                begin
                    go_en     = w.action_ok;
                    go_tgt    = (done_reg || discard_reg) ? S_DELETE : S_CHECK;
                    retry_en  = !w.action_ok;
                    retry_tgt = S_LEAVE;
                end
                S_DELETE:
                begin
                    go_en     = !discard_reg || w.action_ok;
                    go_tgt    = done_reg ? S_EXEC : S_CHECK;
                    retry_en  = !go_en;
                    retry_tgt = S_DELETE;
                end
                S_EXEC:
                begin
                    pulse  = 1'b1;
                    go_en  = 1'b1;
                    go_tgt = S_CHECK;
                end
                default:
                begin
                    go_en  = 1'b1;
                    go_tgt = S_INITIAL;
                end
            endcase

            // failed attempt: timeout first, then the attempt count
            if (retry_en)
            begin
                if (tmo_dur_reg != '0 && tmo_rem_reg == '0)
                begin
                    fail = 1'b1;
                end
                else if (limit_reg != '0)
                begin
                    retry_next = retry_inc;
                    fail       = (retry_inc >= limit_reg);
                end
                if (fail)
                begin
                    go_en  = 1'b1;
                    go_tgt = retry_tgt;
                end
                else
                begin
                    next_rem_next = next_dur_reg;
                end
            end

            // state entry loads the per-state limit, interval and timeout
            if (go_en)
            begin
                new_flag_next = (go_tgt != state_reg);
                state_next    = go_tgt;
                retry_next    = '0;
                if (go_tgt == S_UNAVAIL)
                begin
                    limit_next    = '0;
                    next_dur_next = IDLE_POLL;
                    tmo_dur_next  = '0;
                end
                else if (go_tgt == S_CHECK)
                begin
                    limit_next    = '0;
                    next_dur_next = chk_interval_reg;
                    tmo_dur_next  = '0;
                end
                else if (go_tgt == S_CHKMODE)
                begin
                    limit_next    = '0;
                    next_dur_next = MODE_POLL;
                    tmo_dur_next  = mode_timeout_reg;
                end
                else
                begin
                    limit_next    = req_attempts_reg;
                    next_dur_next = req_interval_reg;
                    tmo_dur_next  = '0;
                end
                next_rem_next = next_dur_next;
                tmo_rem_next  = tmo_dur_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INITIAL;
            new_flag_reg <= 1'b1;
            limit_reg    <= '0;
            retry_reg    <= '0;
            next_dur_reg <= '0;
            next_rem_reg <= '0;
            tmo_dur_reg  <= '0;
            tmo_rem_reg  <= '0;
            size_reg     <= '0;
            offset_reg   <= '0;
            left_reg     <= '0;
            chunk_reg    <= '0;
            done_reg     <= 1'b0;
            discard_reg  <= 1'b0;
        end
        else if (fire)
        begin
            state_reg    <= state_next;
            new_flag_reg <= new_flag_next;
            limit_reg    <= limit_next;
            retry_reg    <= retry_next;
            next_dur_reg <= next_dur_next;
            next_rem_reg <= next_rem_next;
            tmo_dur_reg  <= tmo_dur_next;
            tmo_rem_reg  <= tmo_rem_next;
            size_reg     <= size_next;
            offset_reg   <= offset_next;
            left_reg     <= left_next;
            chunk_reg    <= chunk_next;
            done_reg     <= done_next;
            discard_reg  <= discard_next;
        end
    end

    // ---------------- output register ----------------
    out_word_t out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_word_reg <= '{state_next, ran, next_rem_next, offset_next,
                              chunk_of(left_next), discard_next, done_next,
                              pulse, retry_next};
        end
    end

    assign out_valid        = out_valid_reg;
    assign current_state    = out_word_reg.current_state;
    assign state_ran        = out_word_reg.state_ran;
    assign wait_ms          = out_word_reg.wait_ms;
    assign fetch_offset     = out_word_reg.fetch_offset;
    assign fetch_length     = out_word_reg.fetch_length;
    assign discard_flag     = out_word_reg.discard_flag;
    assign transferred_flag = out_word_reg.transferred_flag;
    assign execute_pulse    = out_word_reg.execute_pulse;
    assign attempts_used    = out_word_reg.attempts_used;

`ifndef NO_ASSERTIONS
    // bytes-left tracker never exceeds the image size
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= size_reg)
        else $error("bytes left exceeds image size");

    // a tick moves timers only
    a_tick_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && w.operation == OP_TICK |=> state_reg == $past(state_reg))
        else $error("tick changed the sequencer state");

    // counted attempts stay below a nonzero limit
    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg != '0 |-> retry_reg < limit_reg)
        else $error("attempt count reached the limit without leaving");

    // execute always hands over to the check state
    a_exec_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && execute_pulse |-> state_ran && current_state == S_CHECK)
        else $error("execute word with wrong follow-up state");
`endif

endmodule

// File: bench/fus_monitor.sv
module fus_monitor
    import fus_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_word_t           in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_word_t          out_word,
    output int                 mismatches,
    output int                 pending
);

    localparam logic [SIZE_W-1:0] CHUNK_MAX = SIZE_W'(CHUNK_BYTES_DEF);

    // register copy
    logic [CNT_W-1:0]   cfg_attempts;
    logic [TIME_W-1:0]  cfg_req_ms;
    logic [TIME_W-1:0]  cfg_chk_ms;
    logic [TIME_W-1:0]  cfg_mode_tmo;
    logic               cfg_updater;

    // sequencer copy
    logic [STATE_W-1:0] seq_state;
    logic               state_new;
    logic [CNT_W-1:0]   try_limit;
    logic [CNT_W-1:0]   try_count;
    logic [TIME_W-1:0]  retry_ms;
    logic [TIME_W-1:0]  retry_left;
    logic [TIME_W-1:0]  tmo_ms;
    logic [TIME_W-1:0]  tmo_left;
    logic [SIZE_W-1:0]  img_size;
    logic [SIZE_W-1:0]  img_offset;
    logic [LEN_W-1:0]   held_len;
    logic               img_done;
    logic               img_discard;

    out_word_t due_words[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got %0h, want %0h", $time, what, got, want);
    endtask

    function automatic void clear_model();
        cfg_attempts = RST_REQ_ATTEMPTS;
        cfg_req_ms   = RST_REQ_INTERVAL;
        cfg_chk_ms   = RST_CHK_INTERVAL;
        cfg_mode_tmo = RST_MODE_TIMEOUT;
        cfg_updater  = 1'b1;
        seq_state    = S_INITIAL;
        state_new    = 1'b1;
        try_limit    = '0;
        try_count    = '0;
        retry_ms     = '0;
        retry_left   = '0;
        tmo_ms       = '0;
        tmo_left     = '0;
        img_size     = '0;
        img_offset   = '0;
        held_len     = '0;
        img_done     = 1'b0;
        img_discard  = 1'b0;
    endfunction

    function automatic void set_register(input logic [IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        unique case (idx)
            REG_REQ_ATTEMPTS: cfg_attempts = val[CNT_W-1:0];
            REG_REQ_INTERVAL: cfg_req_ms   = val[TIME_W-1:0];
            REG_CHK_INTERVAL: cfg_chk_ms   = val[TIME_W-1:0];
            REG_MODE_TIMEOUT: cfg_mode_tmo = val[TIME_W-1:0];
            REG_UPD_PRESENT:  cfg_updater  = val[0];
            default: ;
        endcase
    endfunction

    function automatic void enter_state(input logic [STATE_W-1:0] s,
                                        input logic [CNT_W-1:0] lim,
                                        input logic [TIME_W-1:0] ivl,
                                        input logic [TIME_W-1:0] tmo);
        seq_state  = s;
        try_limit  = lim;
        try_count  = '0;
        retry_ms   = ivl;
        retry_left = ivl;
        tmo_ms     = tmo;
        tmo_left   = tmo;
    endfunction

    function automatic void move_to(input logic [STATE_W-1:0] s);
        state_new = (s != seq_state);
        if (s == S_UNAVAIL)
            enter_state(s, '0, TIME_W'(IDLE_POLL_MS_DEF), '0);
        else if (s == S_CHECK)
            enter_state(s, '0, cfg_chk_ms, '0);
        else if (s == S_CHKMODE)
            enter_state(s, '0, TIME_W'(MODE_POLL_MS_DEF), cfg_mode_tmo);
        else
            enter_state(s, cfg_attempts, cfg_req_ms, '0);
    endfunction

    // failed attempt: give up on timeout or attempt limit, else rearm the wait
    function automatic void retry_or_move(input logic [STATE_W-1:0] fallback);
        logic give_up;
        give_up = 1'b0;
        if (tmo_ms != '0 && tmo_left == '0)
        begin
            give_up = 1'b1;
        end
        else if (try_limit != '0)
        begin
            try_count = try_count + CNT_W'(1);
            if (try_count >= try_limit)
                give_up = 1'b1;
        end
        if (give_up)
            move_to(fallback);
        else
            retry_left = retry_ms;
    endfunction

    function automatic logic [LEN_W-1:0] chunk_window();
        logic [SIZE_W-1:0] left;
        left = (img_offset > img_size) ? '0 : img_size - img_offset;
        if (left > CHUNK_MAX)
            left = CHUNK_MAX;
        return left[LEN_W-1:0];
    endfunction

    function automatic out_word_t step_sequencer(input in_word_t w);
        out_word_t r;
        logic ran;
        logic pulse;
        logic isame;
        logic [SIZE_W-1:0] stored;
        ran   = 1'b0;
        pulse = 1'b0;
        if (w.operation == OP_TICK)
        begin
            if (retry_left != '0)
                retry_left = retry_left - TIME_W'(1);
            if (tmo_left != '0)
                tmo_left = tmo_left - TIME_W'(1);
        end
        else if (state_new || w.force_req || retry_left == '0)
        begin
            state_new = 1'b0;
            ran = 1'b1;
            unique case (seq_state)
                S_UNAVAIL:
                    move_to(S_UNAVAIL);
                S_INITIAL:
                    move_to(cfg_updater ? S_REPORT : S_UNAVAIL);
                S_REPORT:
                    if (w.action_ok) move_to(S_CHECK); else retry_or_move(S_REPORT);
                S_CHECK:
                begin
                    img_size = '0;
                    isame = 1'b1;
                    if (w.action_ok && w.image_ready)
                    begin
                        img_size = w.image_length;
                        isame = w.image_same_version;
                    end
                    if (w.action_ok && w.image_ready && !isame && img_size != '0)
                        move_to(S_AVAIL);
                    else
                        retry_or_move(S_CHECK);
                end
                S_AVAIL:
                    move_to(S_REQMODE);
                S_REQMODE:
                    if (w.action_ok) move_to(S_CHKMODE); else retry_or_move(S_CHECK);
                S_CHKMODE:
                    if (w.action_ok) move_to(S_BEGIN); else retry_or_move(S_CHECK);
                S_BEGIN:
                begin
                    img_done = 1'b0;
                    img_discard = 1'b0;
                    if (w.action_ok)
                    begin
                        img_offset = '0;
                        move_to(S_RETRIEVE);
                    end
                    else
                    begin
                        img_discard = 1'b1;
                        move_to(S_LEAVE);
                    end
                end
                S_RETRIEVE:
                begin
                    stored = SIZE_W'(chunk_window());
                    held_len = '0;
                    if (w.action_ok)
                    begin
                        held_len = stored[LEN_W-1:0];
                        move_to(S_STORE);
                    end
                    else
                    begin
                        retry_or_move(S_LEAVE);
                    end
                end
                S_STORE:
                begin
                    stored = SIZE_W'(held_len);
                    held_len = '0;
                    if (w.action_ok)
                    begin
                        img_offset = img_offset + stored;
                        if (img_size != '0 && img_offset == img_size)
                            move_to(S_FINAL);
                        else
                            move_to(S_RETRIEVE);
                    end
                    else
                    begin
                        move_to(S_LEAVE);
                    end
                end
                S_FINAL:
                begin
                    if (w.action_ok)
                    begin
                        img_done = 1'b1;
                        img_discard = 1'b1;
                    end
                    move_to(S_LEAVE);
                end
                S_LEAVE:
                    if (w.action_ok)
                        move_to((img_done || img_discard) ? S_DELETE : S_CHECK);
                    else
                        retry_or_move(S_LEAVE);
                S_DELETE:
                    if (!img_discard || w.action_ok)
                        move_to(img_done ? S_EXEC : S_CHECK);
                    else
                        retry_or_move(S_DELETE);
                S_EXEC:
                begin
                    pulse = 1'b1;
                    move_to(S_CHECK);
                end
                default:
                    move_to(S_INITIAL);
            endcase
        end
        r.current_state    = seq_state;
        r.state_ran        = ran;
        r.wait_ms          = retry_left;
        r.fetch_offset     = img_offset;
        r.fetch_length     = chunk_window();
        r.discard_flag     = img_discard;
        r.transferred_flag = img_done;
        r.execute_pulse    = pulse;
        r.attempts_used    = try_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            clear_model();
            due_words.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_write)
                set_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                if (due_words.size() == 0)
                begin
                    report_mismatch("word with nothing due, state",
                                    32'(out_word.current_state), '0);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (out_word.current_state !== want.current_state)
                        report_mismatch("current_state", 32'(out_word.current_state),
                                        32'(want.current_state));
                    if (out_word.state_ran !== want.state_ran)
                        report_mismatch("state_ran", 32'(out_word.state_ran),
                                        32'(want.state_ran));
                    if (out_word.wait_ms !== want.wait_ms)
                        report_mismatch("wait_ms", 32'(out_word.wait_ms),
                                        32'(want.wait_ms));
                    if (out_word.fetch_offset !== want.fetch_offset)
                        report_mismatch("fetch_offset", out_word.fetch_offset,
                                        want.fetch_offset);
                    if (out_word.fetch_length !== want.fetch_length)
                        report_mismatch("fetch_length", 32'(out_word.fetch_length),
                                        32'(want.fetch_length));
                    if (out_word.discard_flag !== want.discard_flag)
                        report_mismatch("discard_flag", 32'(out_word.discard_flag),
                                        32'(want.discard_flag));
                    if (out_word.transferred_flag !== want.transferred_flag)
                        report_mismatch("transferred_flag",
                                        32'(out_word.transferred_flag),
                                        32'(want.transferred_flag));
                    if (out_word.execute_pulse !== want.execute_pulse)
                        report_mismatch("execute_pulse", 32'(out_word.execute_pulse),
                                        32'(want.execute_pulse));
                    if (out_word.attempts_used !== want.attempts_used)
                        report_mismatch("attempts_used", 32'(out_word.attempts_used),
                                        32'(want.attempts_used));
                end
            end
            if (in_valid && !in_stall)
                due_words.push_back(step_sequencer(in_word));
        end
        pending = int'(due_words.size());
    end

endmodule

// File: bench/tb.sv
module tb;

    import fus_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int RUN_LIMIT       = 400000;
    // index past the last register; the block must ignore the write
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               cfg_write = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               operation = OP_TICK;
    logic               force_req = 1'b0;
    logic               action_ok = 1'b0;
    logic               image_ready = 1'b0;
    logic               image_same_version = 1'b0;
    logic [SIZE_W-1:0]  image_length = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STATE_W-1:0] current_state;
    logic               state_ran;
    logic [TIME_W-1:0]  wait_ms;
    logic [SIZE_W-1:0]  fetch_offset;
    logic [LEN_W-1:0]   fetch_length;
    logic               discard_flag;
    logic               transferred_flag;
    logic               execute_pulse;
    logic [CNT_W-1:0]   attempts_used;

    int                 mismatches;
    int                 pending;

    // stimulus knobs shared with the receiver process
    bit                 calm = 1'b0;        // final stretch: no idling at all
    bit                 squeeze_req = 1'b0; // ask receiver for one long hold-off

    initial
    begin
        forever #1 clk = ~clk;
    end

    firmware_update_sequencer i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .force_req          (force_req),
        .action_ok          (action_ok),
        .image_ready        (image_ready),
        .image_same_version (image_same_version),
        .image_length       (image_length),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .current_state      (current_state),
        .state_ran          (state_ran),
        .wait_ms            (wait_ms),
        .fetch_offset       (fetch_offset),
        .fetch_length       (fetch_length),
        .discard_flag       (discard_flag),
        .transferred_flag   (transferred_flag),
        .execute_pulse      (execute_pulse),
        .attempts_used      (attempts_used)
    );

    fus_monitor i_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    ({operation, force_req, action_ok, image_ready,
                      image_same_version, image_length}),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   ({current_state, state_ran, wait_ms, fetch_offset, fetch_length,
                      discard_flag, transferred_flag, execute_pulse, attempts_used}),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Put a word on the input and hold it until taken. in_stall is sampled
    // at the falling edge, when everything driven at the rising edge has
    // settled, so the word counts as taken at the following rising edge.
    task automatic offer(input in_word_t w);
        logic taken;
        in_valid           <= 1'b1;
        operation          <= w.operation;
        force_req          <= w.force_req;
        action_ok          <= w.action_ok;
        image_ready        <= w.image_ready;
        image_same_version <= w.image_same_version;
        image_length       <= w.image_length;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    function automatic in_word_t make_word(input logic op, input logic frc,
                                           input logic ok, input logic rdy,
                                           input logic same, input logic [31:0] len);
        in_word_t w;
        w.operation          = op;
        w.force_req          = frc;
        w.action_ok          = ok;
        w.image_ready        = rdy;
        w.image_same_version = same;
        w.image_length       = len;
        return w;
    endfunction

    // Image size for one update attempt. Mostly one to three chunks so the
    // transfer completes; a few exact chunk multiples and a few huge ones.
    function automatic logic [31:0] pick_length();
        unique case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return 32'(CHUNK_BYTES_DEF);
            2:       return 32'(2 * CHUNK_BYTES_DEF);
            3:       return 32'd1;
            default: return $urandom_range(2, 12000);
        endcase
    endfunction

    // Most words follow a plausible update: polls that mostly succeed, with
    // a partner reporting a fresh image of the current size. The rest is
    // noise with every field random.
    function automatic in_word_t random_word(input logic [31:0] img_len);
        in_word_t w;
        if ($urandom_range(0, 4) == 0)
        begin
            w = make_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom);
        end
        else
        begin
            w.operation          = ($urandom_range(0, 5) == 0) ? OP_TICK : OP_POLL;
            w.force_req          = ($urandom_range(0, 2) == 0);
            w.action_ok          = ($urandom_range(0, 9) != 0);
            w.image_ready        = ($urandom_range(0, 11) != 0);
            w.image_same_version = ($urandom_range(0, 9) == 0);
            w.image_length       = img_len;
        end
        return w;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_registers(input logic [CNT_W-1:0] attempts,
                                  input logic [TIME_W-1:0] req_ms,
                                  input logic [TIME_W-1:0] chk_ms,
                                  input logic [TIME_W-1:0] mode_tmo,
                                  input logic present);
        write_reg(REG_REQ_ATTEMPTS, CFG_W'(attempts));
        write_reg(REG_REQ_INTERVAL, req_ms);
        write_reg(REG_CHK_INTERVAL, chk_ms);
        write_reg(REG_MODE_TIMEOUT, mode_tmo);
        write_reg(REG_UPD_PRESENT, CFG_W'(present));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every accepted word has come back.
    // Every word yields exactly one result, so an empty expectation list
    // means the block holds nothing.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Receiver: stretches of random stall bursts and stretches of none,
    // plus one long hold-off on request so the block backs up into in_stall.
    initial
    begin : receiver
        int  run_left;
        bit  choppy;
        bit  squeeze_done;
        run_left = 0;
        choppy = 1'b0;
        squeeze_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                squeeze_done = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = int'($urandom_range(20, 120));
                    choppy = 1'($urandom_range(0, 1));
                end
                run_left--;
                if (!calm && choppy && $urandom_range(0, 5) == 0)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] img_len;
        bit          gappy;
        img_len = 32'd3000;
        gappy = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short waits so the directed walk can run them out with ticks.
        load_registers(8'd2, 27'd3, 27'd2, 27'd2, 1'b1);

        // Directed walk through one complete update.
        offer(make_word(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0)); // timers stay at zero
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // initial -> report
        offer(make_word(OP_POLL, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0)); // report fails once
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // wait not over: no run
        offer(make_word(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
        offer(make_word(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        offer(make_word(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0)); // retry wait expires
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // report ok -> check
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0)); // zero size: not available
        offer(make_word(OP_POLL, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF)); // same version
        offer(make_word(OP_POLL, 1'b1, 1'b1, 1'b1, 1'b0, 32'd4097)); // chunk plus one byte
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // available -> request mode
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // -> check mode
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // -> begin
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // -> retrieve
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // full chunk fetched
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // stored, fetch again
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // last byte fetched
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // stored -> finalize
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // -> leave, image done
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // -> delete
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // -> execute
        offer(make_word(OP_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0)); // restart pulse
        // new image smaller than the old offset: bytes left clamp to zero
        offer(make_word(OP_POLL, 1'b1, 1'b1, 1'b1, 1'b0, 32'd10));

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            unique case (phase)
                0:
                begin
                    write_reg(REG_SPARE, CFG_W'($urandom));
                    // no waits, no attempt limit, no timeout
                    load_registers(8'd0, 27'd0, 27'd0, 27'd0, 1'b1);
                end
                1:  // largest attempt count, one-day waits; updater flag only matters in the initial state
                    load_registers(8'd255, 27'd86400000, 27'd86400000, 27'd86400000, 1'b0);
                2:
                    load_registers(8'd1, 27'd1, 27'd2, 27'd3, 1'b1);
                default:
                    load_registers(CNT_W'($urandom_range(0, 6)),
                                   TIME_W'($urandom_range(0, 8)),
                                   TIME_W'($urandom_range(0, 8)),
                                   TIME_W'($urandom_range(0, 10)), 1'b1);
            endcase
            if (phase == 2)
                squeeze_req <= 1'b1;
            if (phase == PHASES - 1)
                calm = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (k % 40 == 0)
                    gappy = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 24) == 0)
                    img_len = pick_length();
                if (!calm && gappy && $urandom_range(0, 4) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                end
                offer(random_word(img_len));
            end
        end

        wait_drained();
        // two-stage pipeline; the spare wait catches any stray output word
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #RUN_LIMIT;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
